// File: design/sbpe_pkg.sv
// shared types, constants and microcode table for the servo bus packet engine
package sbpe_pkg;

    localparam int MAX_DATA = 6;
    localparam int PAYLOAD_W = 48;
    localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;
    localparam int STEP_W = 3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] INST_WRITE = 8'h03;
    localparam logic [7:0] INST_READ = 8'h02;
    localparam logic [7:0] READ_LEN_BYTE = 8'h04;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [3:0] WRITE_REPLY_LEN = 4'd6;
    localparam logic [3:0] ERR_POS = 4'd4;
    localparam logic [3:0] VLO_POS = 4'd5;
    localparam logic [3:0] VHI_POS = 4'd6;
    localparam logic [3:0] READ2_REPLY_LEN = 4'd8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RXB   = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        SRC_SYNC = 3'd0,
        SRC_ID   = 3'd1,
        SRC_LEN  = 3'd2,
        SRC_INST = 3'd3,
        SRC_REG  = 3'd4,
        SRC_DATA = 3'd5,
        SRC_CHK  = 3'd6
    } t_src;

    typedef enum logic [1:0] {
        JMP_NEXT = 2'd0,
        JMP_MORE = 2'd1,
        JMP_END  = 2'd2
    } t_jmp;

    typedef struct packed {
        t_src              src;
        logic              sum_en;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    function automatic logic [2:0] clamp_write(input logic [2:0] len);
        logic [2:0] n;
        n = len;
        if (len == 3'd0) begin
            n = 3'd1;
        end else if (32'(len) > MAX_DATA) begin
            n = 3'(MAX_DATA);
        end
        return n;
    endfunction

    function automatic logic [2:0] clamp_read(input logic [2:0] len);
        logic [2:0] n;
        n = len;
        if (len == 3'd0) begin
            n = 3'd1;
        end else if (len > 3'd2) begin
            n = 3'd2;
        end
        return n;
    endfunction

    function automatic t_uword urom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            3'd0: w = '{SRC_SYNC, 1'b0, JMP_NEXT, 3'd0};
            3'd1: w = '{SRC_SYNC, 1'b0, JMP_NEXT, 3'd0};
            3'd2: w = '{SRC_ID,   1'b1, JMP_NEXT, 3'd0};
            3'd3: w = '{SRC_LEN,  1'b1, JMP_NEXT, 3'd0};
            3'd4: w = '{SRC_INST, 1'b1, JMP_NEXT, 3'd0};
            3'd5: w = '{SRC_REG,  1'b1, JMP_NEXT, 3'd0};
            3'd6: w = '{SRC_DATA, 1'b1, JMP_MORE, 3'd6};
            3'd7: w = '{SRC_CHK,  1'b0, JMP_END,  3'd0};
        endcase
        return w;
    endfunction

endpackage

// File: design/sbpe_useq.sv
// microcode step counter, control store and jump logic
module sbpe_useq
    import sbpe_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_advance,
    input  logic   i_data_more,
    output logic   o_run,
    output t_uword o_uword
);

    logic              r_run;
    logic              n_run;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    assign o_uword = urom(r_step);
    assign o_run = r_run;

    always_comb begin
        n_run = r_run;
        n_step = r_step;
        if (i_start) begin
            n_run = 1'b1;
            n_step = '0;
        end else if (i_advance) begin
            unique case (o_uword.jmp)
                JMP_NEXT: n_step = r_step + 1'b1;
                JMP_MORE: n_step = i_data_more ? o_uword.target : r_step + 1'b1;
                JMP_END:  n_run = 1'b0;
                default:  n_run = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_step <= '0;
        end else begin
            r_run <= n_run;
            r_step <= n_step;
        end
    end

endmodule

// File: design/sbpe_frame.sv
// frame datapath: latched command, byte select and running checksum
module sbpe_frame
    import sbpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_is_read,
    input  logic [7:0]           i_servo_id,
    input  logic [7:0]           i_reg_addr,
    input  logic [2:0]           i_length,
    input  logic [PAYLOAD_W-1:0] i_payload,
    input  logic                 i_advance,
    input  t_uword               i_uword,
    output logic                 o_data_more,
    output logic [7:0]           o_byte
);

    logic                 r_is_read;
    logic [7:0]           r_id;
    logic [7:0]           r_reg;
    logic [2:0]           r_n;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [7:0]           r_sum;
    logic [2:0]           r_idx;
    logic [7:0]           data_byte;

    always_comb begin
        data_byte = 8'h00;
        if (32'(r_idx) < PAYLOAD_BYTES) begin
            data_byte = r_payload[r_idx*8 +: 8];
        end
    end

    always_comb begin
        unique case (i_uword.src)
            SRC_SYNC: o_byte = SYNC_BYTE;
            SRC_ID:   o_byte = r_id;
            SRC_LEN:  o_byte = r_is_read ? READ_LEN_BYTE : {5'd0, r_n} + 8'd3;
            SRC_INST: o_byte = r_is_read ? INST_READ : INST_WRITE;
            SRC_REG:  o_byte = r_reg;
            SRC_DATA: o_byte = r_is_read ? {5'd0, r_n} : data_byte;
            SRC_CHK:  o_byte = ~r_sum;
            default:  o_byte = 8'h00;
        endcase
    end

    assign o_data_more = !r_is_read && ({1'b0, r_idx} + 4'd1 < {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
            r_idx <= 3'd0;
        end else if (i_start) begin
            r_sum <= 8'h00;
            r_idx <= 3'd0;
        end else if (i_advance) begin
            if (i_uword.sum_en) begin
                r_sum <= r_sum + o_byte;
            end
            if (i_uword.src == SRC_DATA) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_read <= i_is_read;
            r_id <= i_servo_id;
            r_reg <= i_reg_addr;
            r_n <= i_is_read ? clamp_read(i_length) : clamp_write(i_length);
            r_payload <= i_payload;
        end
    end

endmodule

// File: design/sbpe_reply.sv
// reply collection, timeout counter and transaction status
module sbpe_reply
    import sbpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_read,
    input  logic [2:0]  i_length,
    input  logic        i_rx,
    input  logic        i_tick,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_timeout,
    output logic        o_busy,
    output logic        o_done,
    output logic        o_success,
    output logic [15:0] o_read_value
);

    logic        r_busy;
    logic        r_is_read;
    logic [3:0]  r_expected;
    logic [3:0]  r_received;
    logic [15:0] r_elapsed;
    logic [7:0]  r_err;
    logic [7:0]  r_vlo;
    logic [7:0]  r_vhi;
    logic [3:0]  n_received;
    logic [15:0] n_elapsed;
    logic [7:0]  n_err;
    logic [7:0]  n_vlo;
    logic [7:0]  n_vhi;
    logic        rx_done;
    logic        tick_fail;
    logic        ok;

    assign o_busy = r_busy;

    always_comb begin
        n_err = r_err;
        n_vlo = r_vlo;
        n_vhi = r_vhi;
        if (r_received == ERR_POS) begin
            n_err = i_rx_byte;
        end
        if (r_received == VLO_POS) begin
            n_vlo = i_rx_byte;
        end
        if (r_received == VHI_POS) begin
            n_vhi = i_rx_byte;
        end
        n_received = r_received + 4'd1;
        n_elapsed = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    end

    assign rx_done = r_busy && i_rx && (n_received >= r_expected);
    assign tick_fail = r_busy && i_tick && (n_elapsed >= i_timeout);
    assign ok = rx_done && (n_err == 8'h00);
    assign o_done = rx_done || tick_fail;
    assign o_success = ok;

    always_comb begin
        o_read_value = 16'h0000;
        if (ok && r_is_read) begin
            o_read_value = (r_expected == READ2_REPLY_LEN) ? {n_vhi, n_vlo}
                                                           : {8'h00, n_vlo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_is_read <= 1'b0;
            r_expected <= 4'd0;
            r_received <= 4'd0;
            r_elapsed <= 16'd0;
            r_err <= 8'h00;
            r_vlo <= 8'h00;
            r_vhi <= 8'h00;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_is_read <= i_is_read;
            r_expected <= i_is_read ? WRITE_REPLY_LEN + {1'b0, clamp_read(i_length)}
                                    : WRITE_REPLY_LEN;
            r_received <= 4'd0;
            r_elapsed <= 16'd0;
            r_err <= 8'h00;
            r_vlo <= 8'h00;
            r_vhi <= 8'h00;
        end else if (o_done) begin
            r_busy <= 1'b0;
            r_received <= 4'd0;
            r_elapsed <= 16'd0;
            r_err <= n_err;
            r_vlo <= n_vlo;
            r_vhi <= n_vhi;
        end else if (r_busy && i_rx) begin
            r_received <= n_received;
            r_err <= n_err;
            r_vlo <= n_vlo;
            r_vhi <= n_vhi;
        end else if (r_busy && i_tick) begin
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// File: design/servo_bus_packet_engine.sv
// top level of the servo bus packet engine: handshakes, config and result register
//
// channel   direction  handshake                  word
// in        input      i_in_valid / o_in_ready    operation, id, reg, length, payload, rx
// out       output     o_out_valid / i_out_ready  kind, tx_byte, success, read_value, last
// cfg       input      i_cfg_valid / o_cfg_ready  16-bit timeout in ticks
//
// a command runs the microprogram, one frame byte per cycle while the output is not stalled
// received bytes and ticks arrive as input words, status word loads at acceptance
// input is held off while the microprogram runs; output stalls freeze the step counter
// synchronous active-low reset; timeout resets to 3000 and the engine to idle
module servo_bus_packet_engine
    import sbpe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_operation,
    input  logic [7:0]           i_servo_id,
    input  logic [7:0]           i_reg_addr,
    input  logic [2:0]           i_length,
    input  logic [PAYLOAD_W-1:0] i_payload,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [7:0]           o_tx_byte,
    output logic                 o_success,
    output logic [15:0]          o_read_value,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_timeout_ticks;
    logic        r_ov;
    logic        r_kind;
    logic [7:0]  r_tx;
    logic        r_succ;
    logic [15:0] r_val;
    logic        r_last;
    logic        slot_free;
    logic        in_acc;
    logic        is_cmd;
    logic        start;
    logic        run;
    logic        advance;
    logic        data_more;
    logic        busy;
    logic        done;
    logic        ok;
    logic [15:0] rd_val;
    logic [7:0]  fbyte;
    t_uword      uword;
    t_op         op;

    assign op = t_op'(i_operation);
    assign slot_free = !r_ov || i_out_ready;
    assign o_in_ready = !run && slot_free;
    assign in_acc = i_in_valid && o_in_ready;
    assign is_cmd = (op == OP_WRITE) || (op == OP_READ);
    assign start = in_acc && is_cmd && !busy;
    assign advance = run && slot_free;
    assign o_cfg_ready = 1'b1;

    sbpe_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_advance   (advance),
        .i_data_more (data_more),
        .o_run       (run),
        .o_uword     (uword)
    );

    sbpe_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_is_read   (op == OP_READ),
        .i_servo_id  (i_servo_id),
        .i_reg_addr  (i_reg_addr),
        .i_length    (i_length),
        .i_payload   (i_payload),
        .i_advance   (advance),
        .i_uword     (uword),
        .o_data_more (data_more),
        .o_byte      (fbyte)
    );

    sbpe_reply u_reply (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_is_read    (op == OP_READ),
        .i_length     (i_length),
        .i_rx         (in_acc && op == OP_RXB),
        .i_tick       (in_acc && op == OP_TICK),
        .i_rx_byte    (i_rx_byte),
        .i_timeout    (r_timeout_ticks),
        .o_busy       (busy),
        .o_done       (done),
        .o_success    (ok),
        .o_read_value (rd_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (advance || done) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind <= 1'b0;
            r_tx <= fbyte;
            r_succ <= 1'b0;
            r_val <= 16'h0000;
            r_last <= (uword.jmp == JMP_END);
        end else if (done) begin
            r_kind <= 1'b1;
            r_tx <= 8'h00;
            r_succ <= ok;
            r_val <= rd_val;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_tx_byte = r_tx;
    assign o_success = r_succ;
    assign o_read_value = r_val;
    assign o_last = r_last;

endmodule
